FILE: src/tmcs_pkg.sv
// ----------------------------------------------------------------------------
// tmcs_pkg: shared types and codes for the tile-map collision block
// Opcodes, side-code bit positions and map geometry.
// ----------------------------------------------------------------------------
package tmcs_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_TILE  = 2'd0,
      OP_WRITE_SOLID = 2'd1,
      OP_QUERY_PASS  = 2'd2,
      OP_QUERY_SOLID = 2'd3
   } opcode_type;

   // side code: left 3, right 5, top 9, bottom 17
   localparam int SIDE_BIT_ANY    = 0;
   localparam int SIDE_BIT_LEFT   = 1;
   localparam int SIDE_BIT_RIGHT  = 2;
   localparam int SIDE_BIT_TOP    = 3;
   localparam int SIDE_BIT_BOTTOM = 4;
   localparam int SIDE_W          = 5;

   localparam int PIX       = 16;
   localparam int HALF_SHR  = 21;

   // map geometry, tied to the port widths
   localparam int MAP_COLUMNS  = 256;
   localparam int MAP_ROWS     = 16;
   localparam int TILE_PIXELS  = 16;
   localparam int SPRITE_SLOTS = 64;
   localparam int TILE_KINDS   = 256;

endpackage

FILE: src/tile_map_collision_sides.sv
// ----------------------------------------------------------------------------
// tile_map_collision_sides
// Tile map collision sensing with left, right, top and bottom edge probes and stored side codes.
// ----------------------------------------------------------------------------
// A write keeps busy high through the setup and output states. A query scans
// each probe's tile rectangle one map cell at a time through the tile memory
// and then the solid table (both reads are registered), with a tile read,
// solid read and check state per cell visited; each probe adds a setup
// state and stops at its first solid tile. The setup state (slot read) comes
// before the scan; side resolution, the blocking multiply in ST_MUL and
// ST_MUL2 and the output state come after it, with busy high throughout.
// The result beat comes in the cycle busy drops. The receiver cannot stall:
// each result is shown for one cycle on rsp_valid. The tile memory holds no
// reset value; the solid table and side memory are swept clear after reset,
// entry by entry up to the larger of the kind and slot counts, with busy high.
module tile_map_collision_sides (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [7:0]          req_addr_x,
   input  logic [3:0]          req_addr_y,
   input  logic [7:0]          req_write_value,
   input  logic [5:0]          req_sprite_slot,
   input  logic signed [19:0]  req_box_left,
   input  logic signed [19:0]  req_box_top,
   input  logic [11:0]         req_box_width,
   input  logic [11:0]         req_box_height,
   input  logic signed [23:0]  req_vel_x,
   input  logic signed [23:0]  req_vel_y,
   input  logic [15:0]         req_step_dt,
   output logic                rsp_valid,
   output logic                rsp_hit_left,
   output logic                rsp_hit_right,
   output logic                rsp_hit_top,
   output logic                rsp_hit_bottom,
   output logic                rsp_any_tile,
   output logic                rsp_changed,
   output logic signed [23:0]  rsp_new_vel_x,
   output logic signed [23:0]  rsp_new_vel_y,
   output logic signed [19:0]  rsp_shift_x,
   output logic signed [19:0]  rsp_shift_y
);
   import tmcs_pkg::*;

   localparam int CW = (MAP_COLUMNS > 1) ? $clog2(MAP_COLUMNS) : 1;
   localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int AW = CW + RW;
   localparam int KW = (TILE_KINDS > 1) ? $clog2(TILE_KINDS) : 1;
   localparam int SW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
   localparam int TS = TILE_PIXELS * PIX;
   localparam int CLR_N = (TILE_KINDS > SPRITE_SLOTS) ? TILE_KINDS : SPRITE_SLOTS;
   localparam int CLRW = $clog2(CLR_N + 1);
   localparam int XW = 24;   // wide enough for edge coordinates
   localparam int IW = 16;   // tile index range, signed
   localparam logic signed [XW-1:0] P_OFS = XW'(PIX);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_PROBE, ST_TREAD, ST_SREAD, ST_SCHECK,
      ST_SIDES, ST_MUL, ST_MUL2, ST_DONE
   } state_type;

   // memories
   logic [7:0]        tile_mem [MAP_COLUMNS*MAP_ROWS];
   logic              solid_mem [TILE_KINDS];
   logic [SIDE_W-1:0] side_mem [SPRITE_SLOTS];

   state_type state_ff;
   logic [CLRW-1:0] clr_ff;
   logic [1:0]  op_ff;
   logic [7:0]  ax_ff;
   logic [3:0]  ay_ff;
   logic [7:0]  wv_ff;
   logic [5:0]  slot_ff;
   logic signed [XW-1:0] l_ff, t_ff, r_ff, b_ff;
   logic signed [23:0] vx_ff, vy_ff;
   logic [15:0] dt_ff;
   logic [1:0]  pr_ff;          // probe number 0..3
   logic [3:0]  hits_ff;        // left, right, top, bottom in bits 0..3
   logic signed [IW-1:0] cx_ff, cy_ff, x1_ff, y0_ff, y1_ff;
   logic [7:0]  kind_ff;
   logic [SIDE_W-1:0] prev_ff;
   logic        sl_ff, sr_ff, st_ff, sb_ff;
   logic [39:0] magx_ff, magy_ff;
   logic        bx_ff, by_ff;

   // tile index, truncate toward zero
   function automatic logic signed [IW-1:0] tidx(input logic signed [XW-1:0] c);
      logic signed [XW-1:0] q;
      begin
         q = XW'(c / TS);
         return q[IW-1:0];
      end
   endfunction

   // probe rectangle in coordinates
   logic signed [XW-1:0] px0, px1, py0, py1;
   always_comb begin
      case (pr_ff)
         2'd0: begin px0 = l_ff; px1 = l_ff + P_OFS; py0 = t_ff + P_OFS; py1 = b_ff - P_OFS; end
         2'd1: begin px0 = r_ff - P_OFS; px1 = r_ff; py0 = t_ff + P_OFS; py1 = b_ff - P_OFS; end
         2'd2: begin px0 = l_ff + P_OFS; px1 = r_ff - P_OFS; py0 = t_ff; py1 = t_ff + P_OFS; end
         default: begin
            px0 = l_ff + P_OFS; px1 = r_ff - P_OFS; py0 = b_ff - P_OFS; py1 = b_ff;
         end
      endcase
   end

   logic signed [IW-1:0] ix0, ix1, iy0, iy1;
   always_comb begin
      ix0 = tidx(px0);
      ix1 = tidx(px1);
      iy0 = tidx(py0);
      iy1 = tidx(py1);
      if (ix0 < 0) ix0 = '0;
      if (iy0 < 0) iy0 = '0;
      if (ix1 > IW'(MAP_COLUMNS - 1)) ix1 = IW'(MAP_COLUMNS - 1);
      if (iy1 > IW'(MAP_ROWS - 1)) iy1 = IW'(MAP_ROWS - 1);
   end

   logic [AW-1:0] taddr;
   assign taddr = AW'(cx_ff[CW-1:0]) * AW'(MAP_ROWS) + AW'(cy_ff[RW-1:0]);

   // side resolution
   logic pl, prr, pt, pb, fl, fr, ft, fb;
   always_comb begin
      pl = hits_ff[0]; prr = hits_ff[1]; pt = hits_ff[2]; pb = hits_ff[3];
      if (pl && prr && pt && pb) begin
         pl = prev_ff[SIDE_BIT_LEFT];
         prr = prev_ff[SIDE_BIT_RIGHT];
         pt = prev_ff[SIDE_BIT_TOP];
         pb = prev_ff[SIDE_BIT_BOTTOM];
         if ((pl || prr) && !(pt || pb)) begin
            if (vy_ff > 0) pb = 1'b1; else pt = 1'b1;
         end else if ((pt || pb) && !(pl || prr)) begin
            if (vx_ff > 0) prr = 1'b1; else pl = 1'b1;
         end
      end
      fl = pl; fr = prr; ft = pt; fb = pb;
      if ((pl && pt && pb && !prr) || (!pl && pt && pb && prr)) begin
         ft = 1'b0; fb = 1'b0;
      end
      if ((pl && !pt && pb && prr) || (pl && pt && !pb && prr)) begin
         fl = 1'b0; fr = 1'b0;
      end
   end

   logic [SIDE_W-1:0] code;
   assign code = {sb_ff, st_ff, sr_ff, sl_ff, sl_ff | sr_ff | st_ff | sb_ff};

   logic [23:0] absx, absy;
   assign absx = vx_ff[23] ? 24'(-vx_ff) : 24'(vx_ff);
   assign absy = vy_ff[23] ? 24'(-vy_ff) : 24'(vy_ff);

   logic [19:0] qx, qy;
   assign qx = 20'((magx_ff + 40'(1 << (HALF_SHR - 1))) >> HALF_SHR);
   assign qy = 20'((magy_ff + 40'(1 << (HALF_SHR - 1))) >> HALF_SHR);

   logic slot_ok;
   assign slot_ok = 32'(slot_ff) < SPRITE_SLOTS;

   // memories
   always_ff @(posedge clock) begin
      kind_ff <= tile_mem[taddr];
      if (state_ff == ST_SETUP && op_ff == OP_WRITE_TILE &&
          32'(ax_ff) < MAP_COLUMNS && 32'(ay_ff) < MAP_ROWS)
         tile_mem[AW'(ax_ff[CW-1:0]) * AW'(MAP_ROWS) + AW'(ay_ff[RW-1:0])] <= wv_ff;
   end

   logic solid_rd_ff;
   always_ff @(posedge clock) begin
      solid_rd_ff <= solid_mem[kind_ff[KW-1:0]];
      if (state_ff == ST_CLEAR && 32'(clr_ff) < TILE_KINDS)
         solid_mem[clr_ff[KW-1:0]] <= 1'b0;
      else if (state_ff == ST_SETUP && op_ff == OP_WRITE_SOLID && 32'(ax_ff) < TILE_KINDS)
         solid_mem[ax_ff[KW-1:0]] <= wv_ff[0];
   end

   logic [SIDE_W-1:0] side_rd_ff;
   always_ff @(posedge clock) begin
      side_rd_ff <= side_mem[slot_ff[SW-1:0]];
      if (state_ff == ST_CLEAR && 32'(clr_ff) < SPRITE_SLOTS)
         side_mem[clr_ff[SW-1:0]] <= '0;
      else if (state_ff == ST_DONE && op_ff[1] && slot_ok)
         side_mem[slot_ff[SW-1:0]] <= code;
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == CLR_N - 1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  op_ff <= req_opcode; ax_ff <= req_addr_x; ay_ff <= req_addr_y;
                  wv_ff <= req_write_value; slot_ff <= req_sprite_slot;
                  l_ff <= XW'(req_box_left); t_ff <= XW'(req_box_top);
                  r_ff <= XW'(req_box_left) + XW'(req_box_width);
                  b_ff <= XW'(req_box_top) + XW'(req_box_height);
                  vx_ff <= req_vel_x; vy_ff <= req_vel_y; dt_ff <= req_step_dt;
                  pr_ff <= '0; hits_ff <= '0;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               if (op_ff[1]) begin
                  state_ff <= ST_PROBE;
               end else begin
                  sl_ff <= 1'b0; sr_ff <= 1'b0; st_ff <= 1'b0; sb_ff <= 1'b0;
                  bx_ff <= 1'b0; by_ff <= 1'b0;
                  state_ff <= ST_DONE;
               end
            end
            ST_PROBE: begin
               // side read for this slot has landed and holds until the result
               prev_ff <= slot_ok ? side_rd_ff : '0;
               x1_ff <= ix1; y0_ff <= iy0; y1_ff <= iy1;
               cx_ff <= ix0; cy_ff <= iy0;
               if (ix0 > ix1 || iy0 > iy1) begin
                  if (pr_ff == 2'd3) state_ff <= ST_SIDES;
                  pr_ff <= pr_ff + 1'b1;
               end else begin
                  state_ff <= ST_TREAD;
               end
            end
            ST_TREAD: state_ff <= ST_SREAD;   // tile kind lands in kind_ff
            ST_SREAD: state_ff <= ST_SCHECK;  // solid bit lands
            ST_SCHECK: begin
               if (solid_rd_ff && 32'(kind_ff) < TILE_KINDS) begin
                  hits_ff[pr_ff] <= 1'b1;
                  if (pr_ff == 2'd3) state_ff <= ST_SIDES; else state_ff <= ST_PROBE;
                  pr_ff <= pr_ff + 1'b1;
               end else if (cy_ff < y1_ff) begin
                  cy_ff <= cy_ff + 1'b1;
                  state_ff <= ST_TREAD;
               end else if (cx_ff < x1_ff) begin
                  cx_ff <= cx_ff + 1'b1;
                  cy_ff <= y0_ff;
                  state_ff <= ST_TREAD;
               end else begin
                  if (pr_ff == 2'd3) state_ff <= ST_SIDES; else state_ff <= ST_PROBE;
                  pr_ff <= pr_ff + 1'b1;
               end
            end
            ST_SIDES: begin
               sl_ff <= fl; sr_ff <= fr; st_ff <= ft; sb_ff <= fb;
               bx_ff <= op_ff == OP_QUERY_SOLID &&
                        ((fl && vx_ff < 0) || (fr && vx_ff > 0));
               by_ff <= op_ff == OP_QUERY_SOLID &&
                        ((ft && vy_ff < 0) || (fb && vy_ff > 0));
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               magx_ff <= 40'(absx) * 40'(dt_ff);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               magy_ff <= 40'(absy) * 40'(dt_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               rsp_hit_left <= sl_ff; rsp_hit_right <= sr_ff;
               rsp_hit_top <= st_ff; rsp_hit_bottom <= sb_ff;
               rsp_any_tile <= sl_ff | sr_ff | st_ff | sb_ff;
               rsp_changed <= op_ff[1] && (code != prev_ff);
               rsp_new_vel_x <= (!op_ff[1] || bx_ff) ? '0 : vx_ff;
               rsp_new_vel_y <= (!op_ff[1] || by_ff) ? '0 : vy_ff;
               rsp_shift_x <= bx_ff ? (vx_ff[23] ? -$signed(qx) : $signed(qx)) : '0;
               rsp_shift_y <= by_ff ? (vy_ff[23] ? -$signed(qy) : $signed(qy)) : '0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: src/tmcs_checker.sv
// ----------------------------------------------------------------------------
// tmcs_checker: port-level checks for the tile-map collision block
// Watches the command handshake and result strobe.
// ----------------------------------------------------------------------------
module tmcs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit_left,
   input logic rsp_hit_right,
   input logic rsp_hit_top,
   input logic rsp_hit_bottom,
   input logic rsp_any_tile
);
   // a beat accepted makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accepted beat");

   // a result ends the work
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy during result beat");

   // results are single-cycle strobes
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   a_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_any_tile == (rsp_hit_left || rsp_hit_right ||
                                     rsp_hit_top || rsp_hit_bottom))
      else $error("any_tile mismatch");
endmodule

bind tile_map_collision_sides tmcs_checker u_tmcs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_hit_left(rsp_hit_left),
   .rsp_hit_right(rsp_hit_right), .rsp_hit_top(rsp_hit_top),
   .rsp_hit_bottom(rsp_hit_bottom), .rsp_any_tile(rsp_any_tile)
);

FILE: tb/tile_map_collision_sides_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_map_collision_sides_tb
// Self-checking bench for the tile-map collision block. The map columns that
// queries reach are written first, so every query reads a defined cell.
// Directed beats cover fallback, pruning and blocking. Random traffic
// follows, first with sender gaps and then without. Each beat is predicted
// at its accept edge and compared with the result.
// ----------------------------------------------------------------------------
module tile_map_collision_sides_tb;
   import tmcs_pkg::*;

   localparam int COLS       = 256;
   localparam int ROWS       = 16;
   localparam int SLOTS      = 64;
   localparam int KINDS      = 256;
   localparam int TILE_UNITS = 16 * PIX;
   localparam int LIMIT      = 3000000;
   localparam int SOLID_KIND = 7;
   localparam int FILL_COLS  = 8;

   typedef struct {
      opcode_type        op;
      logic [7:0]        ax;
      logic [3:0]        ay;
      logic [7:0]        wv;
      logic [5:0]        slot;
      logic signed [19:0] left;
      logic signed [19:0] top;
      logic [11:0]       wid;
      logic [11:0]       hgt;
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic [15:0]       dt;
   } cmd_type;

   typedef struct packed {
      logic              l, r, t, b, any, chg;
      logic signed [23:0] nvx, nvy;
      logic signed [19:0] shx, shy;
   } sides_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_addr_x = '0;
   logic [3:0]  req_addr_y = '0;
   logic [7:0]  req_write_value = '0;
   logic [5:0]  req_sprite_slot = '0;
   logic signed [19:0] req_box_left = '0, req_box_top = '0;
   logic [11:0] req_box_width = '0, req_box_height = '0;
   logic signed [23:0] req_vel_x = '0, req_vel_y = '0;
   logic [15:0] req_step_dt = '0;
   logic rsp_valid, rsp_hit_left, rsp_hit_right, rsp_hit_top, rsp_hit_bottom;
   logic rsp_any_tile, rsp_changed;
   logic signed [23:0] rsp_new_vel_x, rsp_new_vel_y;
   logic signed [19:0] rsp_shift_x, rsp_shift_y;

   logic [7:0] tile_kind [COLS*ROWS];
   logic       kind_solid [KINDS];
   logic [4:0] side_code [SLOTS];

   sides_type sides_q[$];
   int     errors = 0;
   int     cycles = 0;
   bit     gaps_on = 1;

   tile_map_collision_sides dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic bit probe_hit(longint x0, longint x1, longint y0, longint y1);
      longint ax, bx, ay, by;
      ax = x0 / TILE_UNITS; bx = x1 / TILE_UNITS;
      ay = y0 / TILE_UNITS; by = y1 / TILE_UNITS;
      if (ax < 0) ax = 0;
      if (ay < 0) ay = 0;
      if (bx > COLS - 1) bx = COLS - 1;
      if (by > ROWS - 1) by = ROWS - 1;
      for (longint x = ax; x <= bx; x++)
         for (longint y = ay; y <= by; y++)
            if (kind_solid[tile_kind[x*ROWS + y]]) return 1;
      return 0;
   endfunction

   function automatic logic signed [19:0] half_step(longint v, longint dt);
      longint mag, q;
      mag = (v < 0 ? -v : v) * dt;
      q = (mag + (64'd1 << 20)) >>> HALF_SHR;
      return 20'(v < 0 ? -q : q);
   endfunction

   // advance the mirrored state and return the result this beat causes
   function automatic sides_type predict_sides(cmd_type c);
      sides_type s;
      longint lf, tp, rt, bt, vx, vy;
      logic [4:0] prev, code;
      logic l, r, t, b;
      s = '0;
      if (c.op == OP_WRITE_TILE) begin
         tile_kind[c.ax*ROWS + c.ay] = c.wv;
         return s;
      end
      if (c.op == OP_WRITE_SOLID) begin
         kind_solid[c.ax] = c.wv[0];
         return s;
      end
      lf = c.left; tp = c.top; vx = c.vx; vy = c.vy;
      rt = lf + c.wid; bt = tp + c.hgt;
      prev = side_code[c.slot];
      l = probe_hit(lf, lf + PIX, tp + PIX, bt - PIX);
      r = probe_hit(rt - PIX, rt, tp + PIX, bt - PIX);
      t = probe_hit(lf + PIX, rt - PIX, tp, tp + PIX);
      b = probe_hit(lf + PIX, rt - PIX, bt - PIX, bt);
      s.nvx = c.vx;
      s.nvy = c.vy;
      if (l && r && t && b) begin
         l = prev[SIDE_BIT_LEFT]; r = prev[SIDE_BIT_RIGHT];
         t = prev[SIDE_BIT_TOP];  b = prev[SIDE_BIT_BOTTOM];
         if ((l || r) && !(t || b)) begin
            if (vy > 0) b = 1; else t = 1;
         end else if ((t || b) && !(l || r)) begin
            if (vx > 0) r = 1; else l = 1;
         end
      end
      if ((l && t && b && !r) || (!l && t && b && r)) begin
         t = 0; b = 0;
      end
      if ((l && !t && b && r) || (l && t && !b && r)) begin
         l = 0; r = 0;
      end
      if (c.op == OP_QUERY_SOLID) begin
         if ((l && vx < 0) || (r && vx > 0)) begin
            s.shx = half_step(vx, c.dt);
            s.nvx = '0;
         end
         if ((t && vy < 0) || (b && vy > 0)) begin
            s.shy = half_step(vy, c.dt);
            s.nvy = '0;
         end
      end
      code = '0;
      code[SIDE_BIT_LEFT] = l; code[SIDE_BIT_RIGHT] = r;
      code[SIDE_BIT_TOP] = t;  code[SIDE_BIT_BOTTOM] = b;
      code[SIDE_BIT_ANY] = l | r | t | b;
      s.l = l; s.r = r; s.t = t; s.b = b;
      s.any = code[SIDE_BIT_ANY];
      s.chg = code != prev;
      side_code[c.slot] = code;
      return s;
   endfunction

   always @(posedge clock) begin
      sides_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_hit_left, rsp_hit_right, rsp_hit_top, rsp_hit_bottom, rsp_any_tile,
                rsp_changed, rsp_new_vel_x, rsp_new_vel_y, rsp_shift_x, rsp_shift_y};
         if (sides_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: %p", got);
         end else begin
            want = sides_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   task automatic send_cmd(cmd_type c);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start <= 1;
      req_opcode <= c.op;          req_addr_x <= c.ax;
      req_addr_y <= c.ay;          req_write_value <= c.wv;
      req_sprite_slot <= c.slot;   req_box_left <= c.left;
      req_box_top <= c.top;        req_box_width <= c.wid;
      req_box_height <= c.hgt;     req_vel_x <= c.vx;
      req_vel_y <= c.vy;           req_step_dt <= c.dt;
      do @(posedge clock); while (busy);
      sides_q = {sides_q, predict_sides(c)};
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sides_q.size() != 0) @(posedge clock);
   endtask

   function automatic cmd_type blank_cmd(opcode_type op);
      cmd_type c;
      c = '{op: op, ax: 0, ay: 0, wv: 0, slot: 0, left: 0, top: 0,
            wid: 0, hgt: 0, vx: 0, vy: 0, dt: 0};
      return c;
   endfunction

   task automatic put_tile(int x, int y, int kind);
      cmd_type c;
      c = blank_cmd(OP_WRITE_TILE);
      c.ax = 8'(x); c.ay = 4'(y); c.wv = 8'(kind);
      send_cmd(c);
   endtask

   task automatic put_solid(int kind, bit on);
      cmd_type c;
      c = blank_cmd(OP_WRITE_SOLID);
      c.ax = 8'(kind); c.wv = {7'($urandom), on};
      send_cmd(c);
   endtask

   task automatic query(opcode_type op, int slot, int lf, int tp, int w, int h,
                        int vx, int vy, int dt);
      cmd_type c;
      c = blank_cmd(op);
      c.slot = 6'(slot); c.left = 20'(lf); c.top = 20'(tp);
      c.wid = 12'(w); c.hgt = 12'(h);
      c.vx = 24'(vx); c.vy = 24'(vy); c.dt = 16'(dt);
      send_cmd(c);
   endtask

   // define the map columns that queries reach; nothing is solid yet
   task automatic test_map_fill();
      for (int x = 0; x < FILL_COLS; x++)
         for (int y = 0; y < ROWS; y++)
            put_tile(x, y, 0);
   endtask

   task automatic test_fallback_and_pruning();
      int cx, cy;
      cx = 2 * TILE_UNITS;
      cy = 5 * TILE_UNITS;
      put_solid(SOLID_KIND, 1);
      put_tile(2, 5, SOLID_KIND);
      put_tile(4, 5, SOLID_KIND);
      put_tile(6, 2, SOLID_KIND);
      // all four inside one solid tile with empty history
      query(OP_QUERY_PASS, 1, cx + 16, cy + 16, 100, 100, 5, 5, 100);
      // left, top and bottom hit; prune to left only
      query(OP_QUERY_PASS, 1, 4*TILE_UNITS + 200, cy + 16, 300, 100, 0, 0, 0);
      // all four: stored left, fill bottom from positive vy
      query(OP_QUERY_SOLID, 1, cx + 16, cy + 16, 100, 100, -300, 400, 65535);
      query(OP_QUERY_PASS, 2, 4*TILE_UNITS + 200, cy + 16, 300, 100, 0, 0, 0);
      query(OP_QUERY_SOLID, 2, cx + 16, cy + 16, 100, 100, 300, -400, 65535);
      // top only in history, fill side from vx sign
      query(OP_QUERY_PASS, 3, 6*TILE_UNITS - 100, 2*TILE_UNITS + 200, 400, 300, 0, 0, 0);
      query(OP_QUERY_SOLID, 3, cx + 16, cy + 16, 100, 100, 8388607, -8388608, 65535);
      query(OP_QUERY_SOLID, 3, cx + 16, cy + 16, 100, 100, -8388608, 0, 1);
      // off-map, zero size and maximum size boxes
      query(OP_QUERY_SOLID, 63, -524288, -524288, 4095, 4095, 1, 1, 1);
      query(OP_QUERY_SOLID, 63, 524287, 524287, 0, 0, -1, -1, 65535);
      query(OP_QUERY_SOLID, 0, -2100, cy - 2000, 4095, 4095, 123456, -77, 4321);
      query(OP_QUERY_PASS, 0, 0, 0, 0, 0, 0, 0, 0);
      put_solid(SOLID_KIND, 0);
      query(OP_QUERY_SOLID, 1, cx + 16, cy + 16, 100, 100, 50, 50, 50);
      put_solid(SOLID_KIND, 1);
      put_solid(255, 1);
      put_tile(255, 15, 255);
      query(OP_QUERY_SOLID, 62, 255*TILE_UNITS, 15*TILE_UNITS, 4095, 4095, 9, 9, 9);
   endtask

   task automatic test_random(int count);
      cmd_type c;
      int pick, span, hi;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         c = blank_cmd(OP_QUERY_PASS);
         c.ax = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, FILL_COLS - 1));
         c.ay = 4'($urandom); c.wv = 8'($urandom);
         if (pick < 15) c.op = OP_WRITE_TILE;
         else if (pick < 22) c.op = OP_WRITE_SOLID;
         else c.op = opcode_type'($urandom_range(OP_QUERY_PASS, OP_QUERY_SOLID));
         if (c.op == OP_WRITE_TILE && $urandom_range(0, 1)) c.wv = 8'($urandom_range(0, 15));
         c.slot = 6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
         if ($urandom_range(0, 19) == 0) begin
            // far left of the map, so only column zero is reached
            c.left = 20'(-int'($urandom_range(4096, 524288)));
            c.top = 20'($urandom);
            c.wid = 12'($urandom);  c.hgt = 12'($urandom);
         end else begin
            c.wid = 12'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 800));
            c.hgt = 12'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 800));
            // keep every probe inside the filled columns
            span = (int'(c.wid) > PIX) ? int'(c.wid) : PIX;
            hi = FILL_COLS * TILE_UNITS - 1 - span;
            c.left = 20'(hi - int'($urandom_range(0, 2560)));
            c.top  = 20'(int'($urandom_range(0, ROWS*TILE_UNITS + 1024)) - 512);
         end
         c.vx = $urandom_range(0, 3) == 0 ? 24'(int'($urandom_range(0, 2)) - 1)
                                          : 24'($urandom);
         c.vy = $urandom_range(0, 3) == 0 ? 24'(int'($urandom_range(0, 2)) - 1)
                                          : 24'($urandom);
         c.dt = 16'($urandom);
         send_cmd(c);
      end
   endtask

   initial begin
      for (int k = 0; k < COLS*ROWS; k++) tile_kind[k] = '0;
      for (int k = 0; k < KINDS; k++) kind_solid[k] = 0;
      for (int k = 0; k < SLOTS; k++) side_code[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      test_map_fill();
      test_fallback_and_pruning();
      // seed a solid population for the random part
      for (int k = 0; k < 16; k++) put_solid(k, $urandom_range(0, 2) == 0);
      drain();
      test_random(250);
      gaps_on = 0;
      test_random(100);
      drain();
      repeat (64) @(posedge clock);
      if (errors == 0 && sides_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
src/tmcs_pkg.sv
src/tile_map_collision_sides.sv
src/tmcs_checker.sv
tb/tile_map_collision_sides_tb.sv
